// File: sv/balancing_pid_controller_top_defines.svh
// assertion macros for the balancing pid controller
`ifndef BALANCING_PID_CONTROLLER_TOP_DEFINES_SVH
`define BALANCING_PID_CONTROLLER_TOP_DEFINES_SVH

// clocked check, off while reset is asserted
`define BPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked check that also holds during reset
`define BPC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: sv/bpc_pkg.sv
// shared types, field widths and microcode rom for the balancing pid controller
`default_nettype none

package bpc_pkg;

  localparam int TILT_W      = 25;
  localparam int TARGET_W    = 25;
  localparam int GAIN_W      = 24;
  localparam int DRIVE_W     = 26;
  localparam int OFS_OUT_W   = 24;
  localparam int INTEG_OUT_W = 26;
  localparam int ERR_W       = 26;
  localparam int DIFF_W      = ERR_W + 1;
  localparam int CFG_IDX_W   = 2;

  localparam int S_TDATA_W = 56;
  localparam int M_FIELD_W = DRIVE_W + OFS_OUT_W + INTEG_OUT_W + ERR_W;
  localparam int M_TDATA_W = 104;
  localparam int M_PAD_W   = M_TDATA_W - M_FIELD_W;

  localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST  = 24'sd786432;
  localparam logic signed [GAIN_W-1:0] INTEG_GAIN_RST = 24'sd26214;
  localparam logic signed [GAIN_W-1:0] DERIV_GAIN_RST = 24'sd655360;

  localparam int STEP_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN  = 2'd0,
    REG_INTEG_GAIN = 2'd1,
    REG_DERIV_GAIN = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    OP_CHECK,
    OP_ERR_SAT,
    OP_INTEG_MUL,
    OP_INTEG,
    OP_PROP_SUM,
    OP_DERIV_SUM,
    OP_DRIVE,
    OP_DRIFT,
    OP_EMIT,
    OP_HALT
  } op_e;

  typedef enum logic [1:0] {
    JC_NONE,
    JC_HALT,
    JC_ALWAYS
  } jcond_e;

  localparam logic [STEP_W-1:0] ADDR_EMIT = 4'd8;
  localparam logic [STEP_W-1:0] ADDR_HALT = 4'd9;

  typedef struct packed {
    op_e               op;
    jcond_e            jcond;
    logic [STEP_W-1:0] jaddr;
    logic              last;
  } uword_t;

  typedef struct packed {
    logic busy;
    logic fire;
    op_e  op;
  } dp_ctrl_t;

  typedef struct packed {
    logic halt;
    logic out_free;
  } dp_stat_t;

  function automatic uword_t ucode_rom(input logic [STEP_W-1:0] addr);
    uword_t w;
    w = '{op: OP_EMIT, jcond: JC_NONE, jaddr: '0, last: 1'b1};
    unique case (addr)
      4'd0: w = '{op: OP_CHECK,     jcond: JC_HALT,   jaddr: ADDR_HALT, last: 1'b0};
      4'd1: w = '{op: OP_ERR_SAT,   jcond: JC_NONE,   jaddr: '0,        last: 1'b0};
      4'd2: w = '{op: OP_INTEG_MUL, jcond: JC_NONE,   jaddr: '0,        last: 1'b0};
      4'd3: w = '{op: OP_INTEG,     jcond: JC_NONE,   jaddr: '0,        last: 1'b0};
      4'd4: w = '{op: OP_PROP_SUM,  jcond: JC_NONE,   jaddr: '0,        last: 1'b0};
      4'd5: w = '{op: OP_DERIV_SUM, jcond: JC_NONE,   jaddr: '0,        last: 1'b0};
      4'd6: w = '{op: OP_DRIVE,     jcond: JC_NONE,   jaddr: '0,        last: 1'b0};
      4'd7: w = '{op: OP_DRIFT,     jcond: JC_NONE,   jaddr: '0,        last: 1'b0};
      4'd8: w = '{op: OP_EMIT,      jcond: JC_NONE,   jaddr: '0,        last: 1'b1};
      4'd9: w = '{op: OP_HALT,      jcond: JC_ALWAYS, jaddr: ADDR_EMIT, last: 1'b0};
      default: w = '{op: OP_EMIT, jcond: JC_NONE, jaddr: '0, last: 1'b1};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: sv/bpc_useq.sv
// microcode sequencer: step counter, rom fetch and conditional and unconditional jumps
`default_nettype none

module bpc_useq (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire                logic start_i,
  input  wire  bpc_pkg::dp_stat_t stat_i,
  output bpc_pkg::dp_ctrl_t        ctrl_o
);
  import bpc_pkg::*;

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  uword_t            uw;

  assign uw = ucode_rom(step_q);

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        step_d = '0;
      end
    end else if (uw.last) begin
      if (stat_i.out_free) begin
        busy_d = 1'b0;
      end
    end else begin
      unique case (uw.jcond)
        JC_HALT:   step_d = stat_i.halt ? uw.jaddr : STEP_W'(step_q + 1'b1);
        JC_ALWAYS: step_d = uw.jaddr;
        default:   step_d = STEP_W'(step_q + 1'b1);
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  assign ctrl_o.busy = busy_q;
  assign ctrl_o.fire = busy_q && (!uw.last || stat_i.out_free);
  assign ctrl_o.op   = uw.op;

endmodule

`default_nettype wire

// File: sv/balancing_pid_controller_top.sv
// balancing pid controller top level: config registers, datapath and output stage
// a running tick executes all 9 microcode steps, check through emit; a halted tick runs check, halt and emit
// a new input is accepted only once the current tick has finished; emit stalls while an untaken result is held
// one shared signed multiplier with a registered product sets the step count
// the next input is taken while a result still waits in the output register
// reset: asynchronous active low, clears gains to defaults, state, latch and valids
`default_nettype none

module balancing_pid_controller_top #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tilt_angle [24:0], target_angle [49:25], zero pad
  input  wire logic [bpc_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // running
  input  wire logic                              s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // drive [25:0], balance_offset [49:26], integral [75:50], last_error [101:76], zero pad
  output logic [bpc_pkg::M_TDATA_W-1:0]          m_axis_tdata,
  // halted
  output logic                                   m_axis_tuser,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [bpc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [bpc_pkg::GAIN_W-1:0]        cfg_data_i
);
  import bpc_pkg::*;

  `include "balancing_pid_controller_top_defines.svh"

  localparam int IW = FRAC_BITS + 10;
  localparam int OW = FRAC_BITS + 8;
  localparam int BW = (IW > DIFF_W) ? IW : DIFF_W;
  localparam int PW = GAIN_W + BW;

  localparam logic signed [PW-1:0] TILT_LIM   = PW'(64'sd30 <<< FRAC_BITS);
  localparam logic signed [PW-1:0] BRAKE_TH   = PW'(64'sd10 <<< FRAC_BITS);
  localparam logic signed [PW-1:0] CLAMP_LIM  = PW'(64'sd400 <<< FRAC_BITS);
  localparam logic signed [PW-1:0] DEADBAND   = PW'(64'sd5 <<< FRAC_BITS);
  localparam logic signed [PW-1:0] OFS_LIM    = PW'(64'sd90 <<< FRAC_BITS);
  localparam logic signed [PW-1:0] ERR_MAX    = PW'(64'sd33554431);
  localparam logic signed [PW-1:0] ERR_MIN    = PW'(-64'sd33554432);
  localparam logic signed [GAIN_W-1:0] BRAKE_COEF =
    GAIN_W'(((64'sd15 <<< FRAC_BITS) + 64'sd500) / 64'sd1000);
  localparam logic signed [PW-1:0] DRIFT_STEP =
    PW'(((64'sd15 <<< FRAC_BITS) + 64'sd5000) / 64'sd10000);

  // configuration
  logic signed [GAIN_W-1:0] prop_gain_q, prop_gain_d;
  logic signed [GAIN_W-1:0] integ_gain_q, integ_gain_d;
  logic signed [GAIN_W-1:0] deriv_gain_q, deriv_gain_d;

  // input item
  logic signed [TILT_W-1:0]   tilt_q, tilt_d;
  logic signed [TARGET_W-1:0] target_q, target_d;
  logic                       run_q, run_d;

  // controller state
  logic                    latch_q, latch_d;
  logic signed [IW-1:0]    integ_q, integ_d;
  logic signed [ERR_W-1:0] prev_err_q, prev_err_d;
  logic signed [IW-1:0]    prev_drv_q, prev_drv_d;
  logic signed [OW-1:0]    ofs_q, ofs_d;

  // working registers
  logic signed [PW-1:0]     acc_q, acc_d;
  logic signed [PW-1:0]     prod_q, prod_d;
  logic signed [ERR_W-1:0]  err_q, err_d;
  logic signed [DIFF_W-1:0] diff_q, diff_d;
  logic                     halted_q, halted_d;

  // output stage
  logic                 m_valid_q, m_valid_d;
  logic [M_TDATA_W-1:0] m_data_q, m_data_d;
  logic                 m_user_q, m_user_d;

  dp_ctrl_t ctrl;
  dp_stat_t stat;
  logic     start;

  logic signed [GAIN_W-1:0] mul_a;
  logic signed [BW-1:0]     mul_b;
  logic signed [PW-1:0]     mul_full;
  logic signed [PW-1:0]     prod_sh;

  logic signed [PW-1:0] tilt_w, target_w, ofs_w, integ_w, prev_drv_w;
  logic                 tilt_over, latch_new, halt_now, brake_on;
  logic signed [PW-1:0] err_sum, err_sat, int_sum, int_sat, drv_sat, drv_db;
  logic signed [PW-1:0] ofs_sum, ofs_sat;

  assign start         = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !ctrl.busy;
  assign cfg_ready_o   = 1'b1;

  assign stat.out_free = !m_valid_q || m_axis_tready;
  assign stat.halt     = halt_now;

  bpc_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .ctrl_o  (ctrl)
  );

  assign tilt_w     = PW'(tilt_q);
  assign target_w   = PW'(target_q);
  assign ofs_w      = PW'(ofs_q);
  assign integ_w    = PW'(integ_q);
  assign prev_drv_w = PW'(prev_drv_q);

  assign tilt_over = (tilt_w > TILT_LIM) || (tilt_w < -TILT_LIM);
  assign latch_new = (run_q && latch_q) || tilt_over;
  assign halt_now  = !run_q || latch_new;
  assign brake_on  = (prev_drv_w > BRAKE_TH) || (prev_drv_w < -BRAKE_TH);

  // shared multiplier operand select
  always_comb begin
    mul_a = prop_gain_q;
    mul_b = BW'(err_q);
    case (ctrl.op)
      OP_CHECK: begin
        mul_a = BRAKE_COEF;
        mul_b = BW'(prev_drv_q);
      end
      OP_INTEG_MUL: mul_a = integ_gain_q;
      OP_PROP_SUM: begin
        mul_a = deriv_gain_q;
        mul_b = BW'(diff_q);
      end
      default: ;
    endcase
  end

  assign mul_full = mul_a * mul_b;
  assign prod_sh  = prod_q >>> FRAC_BITS;

  assign err_sum = acc_q + (brake_on ? prod_sh : '0);
  assign err_sat = (err_sum > ERR_MAX) ? ERR_MAX : ((err_sum < ERR_MIN) ? ERR_MIN : err_sum);
  assign int_sum = integ_w + prod_sh;
  assign int_sat = (int_sum > CLAMP_LIM) ? CLAMP_LIM :
                   ((int_sum < -CLAMP_LIM) ? -CLAMP_LIM : int_sum);
  assign drv_sat = (acc_q > CLAMP_LIM) ? CLAMP_LIM :
                   ((acc_q < -CLAMP_LIM) ? -CLAMP_LIM : acc_q);
  assign drv_db  = ((drv_sat < DEADBAND) && (drv_sat > -DEADBAND)) ? '0 : drv_sat;
  assign ofs_sum = (prev_drv_w < 0) ? ofs_w + DRIFT_STEP :
                   ((prev_drv_w > 0) ? ofs_w - DRIFT_STEP : ofs_w);
  assign ofs_sat = (ofs_sum > OFS_LIM) ? OFS_LIM :
                   ((ofs_sum < -OFS_LIM) ? -OFS_LIM : ofs_sum);

  // config writes
  always_comb begin
    prop_gain_d  = prop_gain_q;
    integ_gain_d = integ_gain_q;
    deriv_gain_d = deriv_gain_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PROP_GAIN:  prop_gain_d  = cfg_data_i;
        REG_INTEG_GAIN: integ_gain_d = cfg_data_i;
        REG_DERIV_GAIN: deriv_gain_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // datapath step execution
  always_comb begin
    tilt_d     = tilt_q;
    target_d   = target_q;
    run_d      = run_q;
    latch_d    = latch_q;
    integ_d    = integ_q;
    prev_err_d = prev_err_q;
    prev_drv_d = prev_drv_q;
    ofs_d      = ofs_q;
    acc_d      = acc_q;
    prod_d     = prod_q;
    err_d      = err_q;
    diff_d     = diff_q;
    halted_d   = halted_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_data_d   = m_data_q;
    m_user_d   = m_user_q;

    if (start) begin
      tilt_d   = s_axis_tdata[TILT_W-1:0];
      target_d = s_axis_tdata[TILT_W+TARGET_W-1:TILT_W];
      run_d    = s_axis_tuser;
    end

    if (ctrl.fire) begin
      case (ctrl.op)
        OP_CHECK: begin
          latch_d  = latch_new;
          halted_d = halt_now;
          acc_d    = tilt_w - target_w - ofs_w;
          prod_d   = mul_full;
        end
        OP_ERR_SAT: err_d = ERR_W'(err_sat);
        OP_INTEG_MUL: begin
          prod_d = mul_full;
          diff_d = DIFF_W'(err_q) - DIFF_W'(prev_err_q);
        end
        OP_INTEG: begin
          integ_d = IW'(int_sat);
          prod_d  = mul_full;
        end
        OP_PROP_SUM: begin
          acc_d  = prod_sh + integ_w;
          prod_d = mul_full;
        end
        OP_DERIV_SUM: acc_d = acc_q + prod_sh;
        OP_DRIVE: begin
          prev_drv_d = IW'(drv_db);
          prev_err_d = err_q;
        end
        OP_DRIFT: begin
          if (target_q == '0) begin
            ofs_d = OW'(ofs_sat);
          end
        end
        OP_HALT: begin
          prev_drv_d = '0;
          integ_d    = '0;
        end
        OP_EMIT: begin
          m_valid_d = 1'b1;
          m_user_d  = halted_q;
          m_data_d  = {{M_PAD_W{1'b0}}, prev_err_q, integ_w[INTEG_OUT_W-1:0],
                       ofs_w[OFS_OUT_W-1:0], prev_drv_w[DRIVE_W-1:0]};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q  <= PROP_GAIN_RST;
      integ_gain_q <= INTEG_GAIN_RST;
      deriv_gain_q <= DERIV_GAIN_RST;
      latch_q      <= 1'b0;
      integ_q      <= '0;
      prev_err_q   <= '0;
      prev_drv_q   <= '0;
      ofs_q        <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      prop_gain_q  <= prop_gain_d;
      integ_gain_q <= integ_gain_d;
      deriv_gain_q <= deriv_gain_d;
      latch_q      <= latch_d;
      integ_q      <= integ_d;
      prev_err_q   <= prev_err_d;
      prev_drv_q   <= prev_drv_d;
      ofs_q        <= ofs_d;
      m_valid_q    <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tilt_q   <= tilt_d;
    target_q <= target_d;
    run_q    <= run_d;
    acc_q    <= acc_d;
    prod_q   <= prod_d;
    err_q    <= err_d;
    diff_q   <= diff_d;
    halted_q <= halted_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  `BPC_ASSERT_RST(a_integ_bound, (integ_w <= CLAMP_LIM) && (integ_w >= -CLAMP_LIM), "integral outside clamp")
  `BPC_ASSERT_RST(a_ofs_bound, (ofs_w <= OFS_LIM) && (ofs_w >= -OFS_LIM), "offset outside bound")
  `BPC_ASSERT(a_deadband, (prev_drv_w != 0) |-> ((prev_drv_w >= DEADBAND) || (prev_drv_w <= -DEADBAND)), "drive inside deadband")
  `BPC_ASSERT(a_halt_zero, (m_valid_q && m_user_q) |-> ((m_data_q[DRIVE_W-1:0] == '0) && (m_data_q[M_FIELD_W-ERR_W-1:DRIVE_W+OFS_OUT_W] == '0)), "halted result with nonzero drive or integral")

endmodule

`default_nettype wire
